[hdl/bdhc_pkg.sv]
// Shared types and constants for the button debounce and hold classifier.
// No dependencies; compile first.
`default_nettype none

package bdhc_pkg;

  // Fixed field widths
  localparam int NOW_BITS          = 32;
  localparam int DEBOUNCE_BITS     = 16;
  localparam int PRESS_BITS        = 32;
  localparam int CFG_DATA_BITS     = 32;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int DEFAULT_TIME_BITS = 32;

  // Register reset values
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET  = 16'd30;
  localparam logic [PRESS_BITS-1:0]    LONG_RESET      = 32'd1000;
  localparam logic [PRESS_BITS-1:0]    VERY_LONG_RESET = 32'd5000;

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_LONG      = 2'd1,
    CFG_VERY_LONG = 2'd2
  } cfg_index_t;

  // Press event codes
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SHORT     = 2'd1,
    EV_LONG      = 2'd2,
    EV_VERY_LONG = 2'd3
  } press_event_t;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [DEBOUNCE_BITS-1:0] debounce_time;
    logic [PRESS_BITS-1:0]    long_press_time;
    logic [PRESS_BITS-1:0]    very_long_press_time;
  } bdhc_cfg_t;

endpackage

`default_nettype wire

[hdl/bdhc_if.sv]
// Valid/ready channel interfaces for button samples and press events.
// Depends on bdhc_pkg for field widths.
`default_nettype none

interface bdhc_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          raw_pressed;
  logic [bdhc_pkg::NOW_BITS-1:0] now_time;

  modport source (output valid, output raw_pressed, output now_time, input ready);
  modport sink   (input valid, input raw_pressed, input now_time, output ready);
endinterface

interface bdhc_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink   (input valid, input press_event, output ready);
endinterface

`default_nettype wire

[hdl/bdhc_cfg.sv]
// Configuration register file: debounce and press-duration thresholds.
// Depends on bdhc_pkg.
`default_nettype none

module bdhc_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bdhc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [bdhc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output bdhc_pkg::bdhc_cfg_t                      cfg
);
  import bdhc_pkg::*;

  bdhc_cfg_t regs;

  // Decode the write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_time        <= DEBOUNCE_RESET;
      regs.long_press_time      <= LONG_RESET;
      regs.very_long_press_time <= VERY_LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  regs.debounce_time        <= cfg_data[DEBOUNCE_BITS-1:0];
        CFG_LONG:      regs.long_press_time      <= cfg_data[PRESS_BITS-1:0];
        CFG_VERY_LONG: regs.very_long_press_time <= cfg_data[PRESS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[hdl/bdhc_core.sv]
// Debounce state and hold-time classifier: input register, one pass of
// compare/subtract logic, result register. Depends on bdhc_pkg, bdhc_if.
`default_nettype none

module bdhc_core #(
  parameter int TIME_BITS = bdhc_pkg::DEFAULT_TIME_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bdhc_pkg::bdhc_cfg_t cfg,
  bdhc_sample_if.sink              sample,
  bdhc_event_if.source             result
);
  import bdhc_pkg::*;

  localparam int CMP_BITS = (TIME_BITS > PRESS_BITS) ? TIME_BITS : PRESS_BITS;
  localparam int EXT_BITS = (TIME_BITS > NOW_BITS) ? TIME_BITS : NOW_BITS;

  // Input stage
  logic                 s1_valid;
  logic                 s1_raw;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_adv;

  // Debounce state
  logic                 debounced_pressed;
  logic                 previous_raw;
  logic [TIME_BITS-1:0] change_time;
  logic [TIME_BITS-1:0] press_start_time;

  // Result stage
  logic                 out_valid;
  press_event_t         out_event;

  // Step logic
  logic [EXT_BITS-1:0]  now_ext;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] held;
  logic [CMP_BITS-1:0]  held_ext;
  logic                 raw_change;
  logic                 settled;
  logic                 take;
  press_event_t         ev_next;

  // Result register frees when empty or being drained
  assign s1_adv       = !out_valid || result.ready;
  assign sample.ready = !s1_valid || s1_adv;

  assign now_ext = EXT_BITS'(sample.now_time);

  // Capture the sample transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_raw <= sample.raw_pressed;
      s1_now <= now_ext[TIME_BITS-1:0];
    end
  end

  // Debounce window and hold classification
  always_comb begin
    since_change = s1_now - change_time;
    held         = s1_now - press_start_time;
    held_ext     = CMP_BITS'(held);
    raw_change   = (s1_raw != previous_raw);
    settled      = (since_change >= TIME_BITS'(cfg.debounce_time));
    take         = !raw_change && settled && (s1_raw != debounced_pressed);
    ev_next      = EV_NONE;
    if (take && !s1_raw) begin
      if (held_ext >= CMP_BITS'(cfg.very_long_press_time)) begin
        ev_next = EV_VERY_LONG;
      end else if (held_ext >= CMP_BITS'(cfg.long_press_time)) begin
        ev_next = EV_LONG;
      end else begin
        ev_next = EV_SHORT;
      end
    end
  end

  // Advance state on each processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_pressed <= 1'b0;
      previous_raw      <= 1'b0;
      change_time       <= '0;
      press_start_time  <= '0;
    end else if (s1_valid && s1_adv) begin
      if (raw_change) begin
        previous_raw <= s1_raw;
        change_time  <= s1_now;
      end else if (take) begin
        debounced_pressed <= s1_raw;
        if (s1_raw) begin
          press_start_time <= s1_now;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_event <= ev_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.press_event = out_event;

  // A reported press always comes with a debounced release
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && ev_next != EV_NONE) |=>
      (!debounced_pressed && $past(debounced_pressed)))
    else $error("press event without debounced release");

  // A raw level change yields no event
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && raw_change) |=> (out_valid && out_event == EV_NONE))
    else $error("event reported on raw level change");

  // Debounced level moves only when a sample is processed
  assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s1_adv) |=> $stable(debounced_pressed))
    else $error("debounced level changed without a sample");

  // A stalled input stage keeps its sample
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_now) && $stable(s1_raw)))
    else $error("stalled sample lost");

endmodule

`default_nettype wire

[hdl/button_debounce_hold_classifier.sv]
// Button debounce with press-duration classification, top level.
// A sample is taken into the input register, then its result into the result register.
// Throughput: one sample per cycle; a stalled result holds the pipeline.
// The debounce state sits in one register set updated by a single
// compare/subtract pass, so consecutive samples follow without gaps.
// Reset (rst, synchronous): state released, times 0, registers to defaults.
`default_nettype none

module button_debounce_hold_classifier #(
  parameter int TIME_BITS = bdhc_pkg::DEFAULT_TIME_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  bdhc_sample_if.sink                              sample,
  bdhc_event_if.source                             result,
  input  wire logic                                cfg_we,
  input  wire logic [bdhc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [bdhc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import bdhc_pkg::*;

  bdhc_cfg_t cfg;

  // Threshold registers
  bdhc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Debounce and classify
  bdhc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .result (result)
  );

endmodule

`default_nettype wire
